[sv/sprite_frame_sequencer_assert.svh]
// Assertion macros shared by the sprite frame sequencer RTL.
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check an implication property on every clock edge outside reset.
`define SFS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("sprite_frame_sequencer: assertion failed");
// Check that a condition never holds outside reset.
`define SFS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("sprite_frame_sequencer: forbidden condition seen");
`else
`define SFS_ASSERT(label, clk, rst_n, prop)
`define SFS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[sv/sfs_pkg.sv]
// Types and constants of the sprite frame sequencer.
`default_nettype none

package sfs_pkg;

    // Default position width
    localparam int SFS_FRAME_BITS = 10;

    // Field widths
    localparam int RATE_W  = 16;
    localparam int DT_W    = 16;
    localparam int FIELD_W = 10;
    localparam int PROD_W  = RATE_W + DT_W;
    localparam int CD_W    = 34;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Countdown constants, signed Q10.24
    localparam logic signed [CD_W-1:0] ONE_FRAME = 34'sd16777216;
    localparam logic signed [CD_W-1:0] CD_MIN    = {1'b1, {(CD_W-1){1'b0}}};

    // Item modes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_RATE     = 3'd0,
        REG_FIRST_FRAME    = 3'd1,
        REG_LAST_FRAME     = 3'd2,
        REG_LOOP_ENABLE    = 3'd3,
        REG_REBOUND_ENABLE = 3'd4,
        REG_SHEET_COLUMNS  = 3'd5
    } sfs_reg_t;

    // Input word
    typedef struct packed {
        logic            mode;
        logic [DT_W-1:0] delta_time;
        logic            start_reversed;
    } sfs_in_t;

    // Result word
    typedef struct packed {
        logic [FIELD_W-1:0] frame_index;
        logic [FIELD_W-1:0] sheet_row;
        logic [FIELD_W-1:0] sheet_col;
        logic               finished;
        logic               backward;
    } sfs_out_t;

    // Handshake between sequencer and divider
    typedef struct packed {
        logic busy;
        logic done;
    } sfs_div_status_t;

endpackage

`default_nettype wire

[sv/sfs_divider.sv]
// Iterative restoring divider: one quotient bit per cycle.
`default_nettype none

module sfs_divider
    import sfs_pkg::*;
#(
    parameter int FRAME_BITS = SFS_FRAME_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [FRAME_BITS-1:0] dividend,
    input  wire logic [FIELD_W-1:0]    divisor,
    output sfs_div_status_t            status,
    output logic [FRAME_BITS-1:0]      quotient,
    output logic [FIELD_W-1:0]         remainder
);

    localparam int CNT_W = $clog2(FRAME_BITS + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [FRAME_BITS-1:0] quo_reg, quo_next;
    logic [FIELD_W-1:0]    rem_reg, rem_next;
    logic [FIELD_W-1:0]    divisor_reg, divisor_next;

    logic [FIELD_W:0]   shifted;
    logic [FIELD_W+1:0] trial;

    // Shift in the next dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[FRAME_BITS-1]};
    assign trial   = {1'b0, shifted} - {2'b00, divisor_reg};

    always_comb begin
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start) begin
            // Load operands; zero columns count as one
            quo_next     = dividend;
            rem_next     = '0;
            divisor_next = (divisor == '0) ? FIELD_W'(1) : divisor;
            cnt_next     = CNT_W'(FRAME_BITS);
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            // Keep the difference unless it borrowed
            if (!trial[FIELD_W+1]) begin
                rem_next = trial[FIELD_W-1:0];
                quo_next = {quo_reg[FRAME_BITS-2:0], 1'b1};
            end else begin
                rem_next = shifted[FIELD_W-1:0];
                quo_next = {quo_reg[FRAME_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign status    = '{busy: busy_reg, done: done_reg};
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[sv/sprite_frame_sequencer.sv]
// Sprite frame sequencer top level: sequencer, countdown and result register.
//
// Usage:
//   cfg_*  writes one register per word (index, data); cfg_ready is always
//          high. Write only while the block is idle.
//   s_*    input words: a start word (mode 1) restarts the animation, a
//          tick word (mode 0) carries elapsed time in Q0.16 seconds.
//   m_*    one result word per input word: frame index, sheet row and
//          column, finished and backward flags.
// Flow: the input word passes the MUL, CALC, STEP, DIV and DONE states in
//   order, and the result is registered. s_ready is high only while the
//   sequencer is idle, so a new word is taken only once the last one is
//   through. The row/column divider retires one quotient bit per cycle
//   while the sequencer waits in ST_DIV.
// Stalls: a finished result waits in the output register; the next input
//   word is still taken and worked on, then held until that register frees.
// Reset: config registers return to defaults (sheet_columns 1, others 0); the
//   animation is idle and reports finished until a start word arrives.
`default_nettype none

module sprite_frame_sequencer
    import sfs_pkg::*;
#(
    parameter int FRAME_BITS = SFS_FRAME_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire sfs_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output sfs_out_t                   m_data
);

`include "sprite_frame_sequencer_assert.svh"

    // Wide enough for positions, register values and a sign
    localparam int EW = ((FRAME_BITS > FIELD_W) ? FRAME_BITS : FIELD_W) + 2;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_CALC = 6'b000100,
        ST_STEP = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [RATE_W-1:0]  frame_rate_reg;
    logic [FIELD_W-1:0] first_frame_reg;
    logic [FIELD_W-1:0] last_frame_reg;
    logic               loop_enable_reg;
    logic               rebound_enable_reg;
    logic [FIELD_W-1:0] sheet_columns_reg;

    // Animation state
    logic signed [CD_W-1:0] cd_reg, cd_next;
    logic [FRAME_BITS-1:0]  pos_reg, pos_next;
    logic                   back_reg, back_next;
    logic                   fin_reg, fin_next;
    logic                   step_reg, step_next;

    // Work registers
    sfs_in_t             in_reg;
    logic [PROD_W-1:0]   product_reg;
    logic                m_valid_reg;
    sfs_out_t            m_data_reg;

    // Divider hookup
    logic                  div_start;
    logic [FRAME_BITS-1:0] div_dividend;
    sfs_div_status_t       div_status;
    logic [FRAME_BITS-1:0] div_quotient;
    logic [FIELD_W-1:0]    div_remainder;

    // Countdown arithmetic
    logic signed [CD_W:0]   cd_diff;
    logic signed [CD_W-1:0] cd_sat;
    logic                   cd_expired;

    // Frame step arithmetic
    logic signed [EW-1:0] pos_s, first_s, last_s, pos_dec, pos_inc, adv_e;
    logic [EW-1:0]        start_e;
    logic [FRAME_BITS-1:0] adv_pos, start_pos;
    logic                 adv_back, adv_fin;
    logic [EW-1:0]        index_e, row_e;

    logic s_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Take configuration writes; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rate_reg     <= '0;
            first_frame_reg    <= '0;
            last_frame_reg     <= '0;
            loop_enable_reg    <= 1'b0;
            rebound_enable_reg <= 1'b0;
            sheet_columns_reg  <= FIELD_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FRAME_RATE:     frame_rate_reg     <= cfg_data[RATE_W-1:0];
                REG_FIRST_FRAME:    first_frame_reg    <= cfg_data[FIELD_W-1:0];
                REG_LAST_FRAME:     last_frame_reg     <= cfg_data[FIELD_W-1:0];
                REG_LOOP_ENABLE:    loop_enable_reg    <= cfg_data[0];
                REG_REBOUND_ENABLE: rebound_enable_reg <= cfg_data[0];
                REG_SHEET_COLUMNS:  sheet_columns_reg  <= cfg_data[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    // Subtract elapsed frames, saturate at the floor, detect an expired frame
    assign cd_diff    = {cd_reg[CD_W-1], cd_reg} - $signed({1'b0, 2'b00, product_reg});
    assign cd_sat     = (cd_diff[CD_W] && !cd_diff[CD_W-1]) ? CD_MIN : cd_diff[CD_W-1:0];
    assign cd_expired = cd_sat[CD_W-1] || (cd_sat == '0);

    // Step one frame and handle the ends of the animation
    assign pos_s   = $signed(EW'(pos_reg));
    assign first_s = $signed(EW'(first_frame_reg));
    assign last_s  = $signed(EW'(last_frame_reg));
    assign pos_dec = pos_s - EW'(1);
    assign pos_inc = pos_s + EW'(1);

    always_comb begin
        adv_e    = pos_dec;
        adv_back = back_reg;
        adv_fin  = fin_reg;
        if (back_reg) begin
            adv_e = pos_dec;
            if (pos_dec < first_s) begin
                if (loop_enable_reg && rebound_enable_reg) begin
                    adv_back = 1'b0;
                    adv_e    = first_s + EW'(1);
                end else if (loop_enable_reg) begin
                    adv_e = last_s;
                end else begin
                    adv_fin = 1'b1;
                    adv_e   = first_s;
                end
            end
        end else begin
            adv_e = pos_inc;
            if (pos_inc > last_s) begin
                if (rebound_enable_reg) begin
                    adv_back = 1'b1;
                    adv_e    = last_s - EW'(1);
                end else if (loop_enable_reg) begin
                    adv_e = first_s;
                end else begin
                    adv_fin = 1'b1;
                    adv_e   = last_s;
                end
            end
        end
    end

    assign adv_pos   = adv_e[FRAME_BITS-1:0];
    assign start_e   = EW'(in_reg.start_reversed ? last_frame_reg : first_frame_reg);
    assign start_pos = start_e[FRAME_BITS-1:0];

    // Launch the row/column split on the position left after the step
    assign div_start    = (state_reg == ST_STEP);
    assign div_dividend = step_reg ? adv_pos : pos_reg;

    sfs_divider #(
        .FRAME_BITS (FRAME_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (sheet_columns_reg),
        .status    (div_status),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign index_e = EW'(pos_reg);
    assign row_e   = EW'(div_quotient);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cd_next    = cd_reg;
        pos_next   = pos_reg;
        back_next  = back_reg;
        fin_next   = fin_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                step_next = 1'b0;
                if (in_reg.mode == MODE_START) begin
                    back_next = in_reg.start_reversed;
                    pos_next  = start_pos;
                    cd_next   = ONE_FRAME;
                    fin_next  = 1'b0;
                end else if (!fin_reg) begin
                    cd_next   = cd_expired ? (cd_sat + ONE_FRAME) : cd_sat;
                    step_next = cd_expired;
                end
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (step_reg) begin
                    pos_next  = adv_pos;
                    back_next = adv_back;
                    fin_next  = adv_fin;
                end
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_status.done) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cd_reg      <= '0;
            pos_reg     <= '0;
            back_reg    <= 1'b0;
            fin_reg     <= 1'b1;
            step_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cd_reg    <= cd_next;
            pos_reg   <= pos_next;
            back_reg  <= back_next;
            fin_reg   <= fin_next;
            step_reg  <= step_next;
            // Hold the result until taken; load the next when free
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the input word, the rate product and the result word
    always_ff @(posedge aclk) begin
        if (s_fire) in_reg <= s_data;
        if (state_reg == ST_MUL) begin
            product_reg <= frame_rate_reg * in_reg.delta_time;
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_data_reg.frame_index <= index_e[FIELD_W-1:0];
            m_data_reg.sheet_row   <= row_e[FIELD_W-1:0];
            m_data_reg.sheet_col   <= div_remainder;
            m_data_reg.finished    <= fin_reg;
            m_data_reg.backward    <= back_reg;
        end
    end

    `SFS_ASSERT(a_accept_starts_work, aclk, aresetn, s_fire |=> (state_reg == ST_MUL))
    `SFS_ASSERT_NEVER(a_div_done_out_of_place, aclk, aresetn,
        div_status.done && (state_reg != ST_DIV))
    `SFS_ASSERT(a_result_loaded, aclk, aresetn,
        ((state_reg == ST_DONE) && (!m_valid_reg || m_ready)) |=> m_valid_reg)
    `SFS_ASSERT(a_no_step_holds_pos, aclk, aresetn,
        ((state_reg == ST_STEP) && !step_reg) |=> $stable(pos_reg))
    `SFS_ASSERT_NEVER(a_div_idle_in_div, aclk, aresetn,
        (state_reg == ST_DIV) && !div_status.busy && !div_status.done)

endmodule

`default_nettype wire

[test/tb_sprite_frame_sequencer.sv]
// Self-checking testbench for the sprite frame sequencer: predictor, stimulus and checks.
`default_nettype none

module tb_sprite_frame_sequencer;
    import sfs_pkg::*;

    localparam int FRAME_BITS = SFS_FRAME_BITS;
    // Register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // Predict the frame word for each accepted input word and check results in order
    class frame_scoreboard;
        logic [RATE_W-1:0]     frame_rate;
        logic [FIELD_W-1:0]    first_frame;
        logic [FIELD_W-1:0]    last_frame;
        logic [FIELD_W-1:0]    sheet_columns;
        logic                  loop_en;
        logic                  rebound_en;
        longint                countdown;
        logic [FRAME_BITS-1:0] position;
        bit                    backward;
        bit                    finished;
        sfs_out_t              expected_frames[$];
        int                    mismatches;

        function new();
            frame_rate    = '0;
            first_frame   = '0;
            last_frame    = '0;
            sheet_columns = FIELD_W'(1);
            loop_en       = 1'b0;
            rebound_en    = 1'b0;
            countdown     = 0;
            position      = '0;
            backward      = 1'b0;
            finished      = 1'b1;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_RATE:     frame_rate    = data[RATE_W-1:0];
                REG_FIRST_FRAME:    first_frame   = data[FIELD_W-1:0];
                REG_LAST_FRAME:     last_frame    = data[FIELD_W-1:0];
                REG_LOOP_ENABLE:    loop_en       = data[0];
                REG_REBOUND_ENABLE: rebound_en    = data[0];
                REG_SHEET_COLUMNS:  sheet_columns = data[FIELD_W-1:0];
                default: ;
            endcase
        endfunction

        // Step one frame, bouncing, wrapping or finishing at the ends
        function void step_position();
            int pos;
            pos = int'(position);
            if (backward) begin
                pos = pos - 1;
                if (pos < int'(first_frame)) begin
                    if (loop_en && rebound_en) begin
                        backward = 1'b0;
                        pos = int'(first_frame) + 1;
                    end else if (loop_en) begin
                        pos = int'(last_frame);
                    end else begin
                        finished = 1'b1;
                        pos = int'(first_frame);
                    end
                end
            end else begin
                pos = pos + 1;
                if (pos > int'(last_frame)) begin
                    if (rebound_en) begin
                        backward = 1'b1;
                        pos = int'(last_frame) - 1;
                    end else if (loop_en) begin
                        pos = int'(first_frame);
                    end else begin
                        finished = 1'b1;
                        pos = int'(last_frame);
                    end
                end
            end
            position = pos[FRAME_BITS-1:0];
        endfunction

        function void note_word(sfs_in_t w);
            sfs_out_t r;
            int cols;
            int quot;
            int rem;
            if (w.mode == MODE_START) begin
                backward  = w.start_reversed;
                position  = w.start_reversed ? last_frame : first_frame;
                countdown = longint'(ONE_FRAME);
                finished  = 1'b0;
            end else if (!finished) begin
                countdown = countdown - longint'(frame_rate) * longint'(w.delta_time);
                if (countdown < longint'(CD_MIN))
                    countdown = longint'(CD_MIN);
                if (countdown <= 0) begin
                    countdown = countdown + longint'(ONE_FRAME);
                    step_position();
                end
            end
            cols = (sheet_columns == '0) ? 1 : int'(sheet_columns);
            quot = int'(position) / cols;
            rem  = int'(position) % cols;
            r.frame_index = position[FIELD_W-1:0];
            r.sheet_row   = quot[FIELD_W-1:0];
            r.sheet_col   = rem[FIELD_W-1:0];
            r.finished    = finished;
            r.backward    = backward;
            expected_frames.push_back(r);
        endfunction

        function void check_word(sfs_out_t got);
            sfs_out_t want;
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("stray result word: idx %0d row %0d col %0d fin %0b bwd %0b",
                             got.frame_index, got.sheet_row, got.sheet_col,
                             got.finished, got.backward);
                return;
            end
            want = expected_frames.pop_front();
            if (got.frame_index !== want.frame_index || got.sheet_row !== want.sheet_row ||
                got.sheet_col !== want.sheet_col || got.finished !== want.finished ||
                got.backward !== want.backward) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("frame word wrong: want %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                             want.frame_index, want.sheet_row, want.sheet_col,
                             want.finished, want.backward,
                             got.frame_index, got.sheet_row, got.sheet_col,
                             got.finished, got.backward);
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    sfs_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    sfs_out_t              m_data;

    frame_scoreboard sb = new();
    int  words_sent      = 0;
    int  words_checked   = 0;
    int  ready_hold      = 0;
    bit  sender_idles    = 1'b1;
    bit  receiver_stalls = 1'b1;

    sprite_frame_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watch all three channels; note the input word before checking the result word
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.note_word(s_data);
            if (m_valid && m_ready) begin
                sb.check_word(m_data);
                words_checked++;
            end
        end
    end

    // Stall the result channel in bursts, mostly short
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 9) < 3) begin
            ready_hold <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                       : $urandom_range(15, 50);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pad10(logic [FIELD_W-1:0] v);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom_range(0, 65535));
        d[FIELD_W-1:0] = v;
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pad1(logic v);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom_range(0, 65535));
        d[0] = v;
        return d;
    endfunction

    function automatic sfs_in_t tick_word(logic [DT_W-1:0] dt);
        sfs_in_t w;
        w.mode           = MODE_TICK;
        w.delta_time     = dt;
        w.start_reversed = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic sfs_in_t start_word(logic rev);
        sfs_in_t w;
        w.mode           = MODE_START;
        w.delta_time     = DT_W'($urandom_range(0, 65535));
        w.start_reversed = rev;
        return w;
    endfunction

    // Hold valid until the word is taken, then idle if the phase asks for it
    task automatic send_word(input sfs_in_t w);
        int gap;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        gap = sender_idles ? idle_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every result word is back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (words_checked != words_sent) @(posedge aclk);
    endtask

    task automatic write_reg_word(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write the full register set, spare indexes last
    task automatic program_regs(input logic [RATE_W-1:0] rate,
                                input logic [FIELD_W-1:0] first,
                                input logic [FIELD_W-1:0] last,
                                input logic loop, input logic rebound,
                                input logic [FIELD_W-1:0] cols);
        write_reg_word(REG_FRAME_RATE, rate);
        write_reg_word(REG_FIRST_FRAME, pad10(first));
        write_reg_word(REG_LAST_FRAME, pad10(last));
        write_reg_word(REG_LOOP_ENABLE, pad1(loop));
        write_reg_word(REG_REBOUND_ENABLE, pad1(rebound));
        write_reg_word(REG_SHEET_COLUMNS, pad10(cols));
        write_reg_word(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg_word(REG_SPARE_B, CFG_DATA_W'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
    endtask

    // Short directed walk over every end-of-animation case
    task automatic run_directed();
        // finish without loop, idle before start, zero columns
        program_regs(16'hFFFF, 10'd2, 10'd3, 1'b0, 1'b0, 10'd0);
        send_word(tick_word(16'hFFFF));
        send_word(start_word(1'b0));
        send_word(tick_word(16'hFFFF));
        send_word(tick_word(16'hFFFF));
        send_word(tick_word(16'h0000));
        drain_results();
        // wrap at both ends, widest sheet
        program_regs(16'hFFFF, 10'd2, 10'd3, 1'b1, 1'b0, 10'd1023);
        send_word(start_word(1'b1));
        send_word(tick_word(16'hFFFF));
        send_word(tick_word(16'hFFFF));
        send_word(start_word(1'b0));
        send_word(tick_word(16'hFFFF));
        send_word(tick_word(16'hFFFF));
        send_word(tick_word(16'h0000));
        drain_results();
        // bounce on a one-frame animation at zero, position wraps to the top
        program_regs(16'hFFFF, 10'd0, 10'd0, 1'b1, 1'b1, 10'd0);
        send_word(start_word(1'b0));
        send_word(tick_word(16'hFFFF));
        send_word(start_word(1'b1));
        send_word(tick_word(16'hFFFF));
        send_word(tick_word(16'hFFFF));
        drain_results();
        // first above last, rebound without loop
        program_regs(16'hFFFF, 10'd5, 10'd3, 1'b0, 1'b1, 10'd7);
        send_word(start_word(1'b0));
        send_word(tick_word(16'hFFFF));
        send_word(tick_word(16'hFFFF));
        send_word(start_word(1'b1));
        send_word(tick_word(16'hFFFF));
        drain_results();
        // countdown landing exactly on zero
        program_regs(16'h0200, 10'd0, 10'd1023, 1'b0, 1'b0, 10'd1023);
        send_word(start_word(1'b0));
        send_word(tick_word(16'h7FFF));
        send_word(tick_word(16'h0001));
        send_word(tick_word(16'h0000));
        drain_results();
    endtask

    // One random phase: fresh settings, then mostly ticks with restarts
    task automatic run_phase(input int k);
        logic [RATE_W-1:0]  rate;
        logic [FIELD_W-1:0] first;
        logic [FIELD_W-1:0] last;
        logic [FIELD_W-1:0] cols;
        logic [DT_W-1:0]    dt;
        sfs_in_t            w;
        int                 n_items;
        int                 busy_items;
        int                 r;
        bit                 idle_now;

        case (k)
            0:       rate = 16'h0000;
            1:       rate = 16'hFFFF;
            2:       rate = 16'h0100;
            default: rate = RATE_W'($urandom_range(16'h0400, 16'h3000));
        endcase
        case (k)
            2: begin
                first = 10'd0;
                last  = 10'd0;
            end
            3: begin
                first = FIELD_W'($urandom_range(1016, 1022));
                last  = 10'd1023;
            end
            4: begin
                last  = FIELD_W'($urandom_range(0, 1000));
                first = last + FIELD_W'($urandom_range(1, 5));
            end
            5: begin
                first = FIELD_W'($urandom_range(0, 20));
                last  = first;
            end
            default: begin
                first = FIELD_W'($urandom_range(0, 1015));
                last  = first + FIELD_W'($urandom_range(1, 8));
            end
        endcase
        case (k)
            0:       cols = 10'd0;
            1:       cols = 10'd1023;
            2:       cols = 10'd1;
            6:       cols = FIELD_W'($urandom_range(500, 1023));
            default: cols = FIELD_W'($urandom_range(1, 40));
        endcase
        sender_idles    = (k % 3 != 2) && (k != 7);
        receiver_stalls = (k % 3 != 1) && (k != 7);
        program_regs(rate, first, last, 1'((k % 4) >> 1), 1'(k % 4), cols);

        n_items    = (k == 0) ? 60 : 136;
        busy_items = 0;
        send_word(start_word(1'($urandom_range(0, 1))));
        while (busy_items < n_items) begin
            idle_now = sb.finished;
            if ((idle_now && $urandom_range(0, 1) == 1) || $urandom_range(0, 99) < 5) begin
                w = start_word(1'($urandom_range(0, 1)));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    dt = DT_W'($urandom_range(0, 65535));
                else if (r < 85)
                    dt = DT_W'($urandom_range(0, 16'h0400));
                else if (r < 90)
                    dt = 16'h0000;
                else if (r < 95)
                    dt = 16'hFFFF;
                else
                    dt = 16'h8000;
                w = tick_word(dt);
            end
            busy_items++;
            send_word(w);
            // now and then let everything come back before going on
            if ($urandom_range(0, 149) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int k = 0; k < 9; k++)
            run_phase(k);
        drain_results();
        repeat (FRAME_BITS + 10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
